// ===== design/tmcw_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the text-mode console writer.
// No dependencies; every other design file except tmcw_ram imports this package.
package tmcw_pkg;

    localparam int DEFAULT_COLUMNS = 80;
    localparam int DEFAULT_ROWS = 25;
    localparam int DEFAULT_QUEUE_DEPTH = 4;

    localparam logic [7:0] DEFAULT_ATTR_RESET = 8'd7;
    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] SPACE_CODE = 8'd32;
    localparam logic [7:0] FILL_CHAR = 8'd0;

    localparam logic [1:0] CMD_PUT = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_BACKSPACE = 2'd2;
    localparam logic [1:0] CMD_READ = 2'd3;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] char_code;
        logic       use_own_attribute;
        logic [7:0] attribute;
        logic [4:0] read_row;
        logic [6:0] read_column;
    } t_item;

    typedef struct packed {
        logic [15:0] cell_value;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_column;
        logic        scrolled;
        logic        echo_valid;
        logic [7:0]  echo_byte;
    } t_result;

    typedef enum logic [2:0] {
        OP_PUT,
        OP_NEWLINE,
        OP_CLEAR,
        OP_BACKSPACE,
        OP_READ
    } t_op_kind;

    typedef struct packed {
        t_op_kind   kind;
        logic [7:0] attr;
        logic [7:0] ch;
        logic [7:0] echo_byte;
        logic [4:0] read_row;
        logic [6:0] read_column;
        logic       read_ok;
    } t_op;

    typedef struct packed {
        logic init_busy;
    } t_back_status;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_FILL
    } t_back_state;

endpackage

// ===== design/tmcw_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module tmcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/tmcw_front.sv =====
`timescale 1ns / 1ps
// Front end: holds the default attribute register, accepts items and turns them into operations.
// Depends on tmcw_pkg.
module tmcw_front #(
    parameter int COLUMNS = tmcw_pkg::DEFAULT_COLUMNS,
    parameter int ROWS = tmcw_pkg::DEFAULT_ROWS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  tmcw_pkg::t_item        i_in_item,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [7:0]             i_cfg_data,
    input  logic                   i_queue_full,
    input  tmcw_pkg::t_back_status i_status,
    output logic                   o_push,
    output tmcw_pkg::t_op          o_push_op
);
    import tmcw_pkg::*;

    logic [7:0] r_default_attr;
    t_op        op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_attr <= DEFAULT_ATTR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_default_attr <= i_cfg_data;
        end
    end

    always_comb begin
        op.attr = i_in_item.use_own_attribute ? i_in_item.attribute : r_default_attr;
        op.ch = i_in_item.char_code;
        op.echo_byte = 8'd0;
        op.read_row = i_in_item.read_row;
        op.read_column = i_in_item.read_column;
        op.read_ok = (32'(i_in_item.read_row) < ROWS) && (32'(i_in_item.read_column) < COLUMNS);
        op.kind = OP_READ;
        unique case (i_in_item.cmd)
            CMD_PUT: begin
                op.kind = (i_in_item.char_code == NEWLINE_CODE) ? OP_NEWLINE : OP_PUT;
                op.echo_byte = i_in_item.char_code;
            end
            CMD_CLEAR: begin
                op.kind = OP_CLEAR;
            end
            CMD_BACKSPACE: begin
                op.kind = OP_BACKSPACE;
                op.ch = SPACE_CODE;
            end
            default: begin
                op.kind = OP_READ;
            end
        endcase
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_stall = i_queue_full || i_status.init_busy;
    assign o_push = i_in_valid && !o_in_stall;
    assign o_push_op = op;
endmodule

// ===== design/tmcw_fifo.sv =====
`timescale 1ns / 1ps
// Short operation queue between the front end and the back end.
// Depends on tmcw_pkg.
module tmcw_fifo #(
    parameter int DEPTH = tmcw_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tmcw_pkg::t_op i_push_op,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_not_empty,
    output tmcw_pkg::t_op o_op
);
    import tmcw_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_op              r_slots [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wptr;
    logic [PTR_W-1:0] n_rptr;
    logic [CNT_W-1:0] n_count;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_count <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wptr] <= i_push_op;
        end
    end

    assign o_full = (r_count == FULL_CNT);
    assign o_not_empty = (r_count != '0);
    assign o_op = r_slots[r_rptr];
endmodule

// ===== design/tmcw_back.sv =====
`timescale 1ns / 1ps
// Back end: cursor, screen memory sequencer (reset clear, clear, scroll, fill) and result register.
// Depends on tmcw_pkg and tmcw_ram.
module tmcw_back #(
    parameter int COLUMNS = tmcw_pkg::DEFAULT_COLUMNS,
    parameter int ROWS = tmcw_pkg::DEFAULT_ROWS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_op_valid,
    input  tmcw_pkg::t_op          i_op,
    output logic                   o_op_pop,
    output tmcw_pkg::t_back_status o_status,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output tmcw_pkg::t_result      o_out_item
);
    import tmcw_pkg::*;

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int ROW_W = $clog2(ROWS);
    localparam int COL_W = $clog2(COLUMNS);
    localparam logic [ADDR_W-1:0] COLS_A = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] COPY_END = ADDR_W'((ROWS - 1) * COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);

    t_back_state       r_state;
    t_back_state       n_state;
    logic [ROW_W-1:0]  r_row;
    logic [ROW_W-1:0]  n_row;
    logic [COL_W-1:0]  r_col;
    logic [COL_W-1:0]  n_col;
    logic [ADDR_W-1:0] r_idx;
    logic [ADDR_W-1:0] n_idx;
    logic              r_cp_valid;
    logic              n_cp_valid;
    logic [ADDR_W-1:0] r_cp_addr;
    logic [ADDR_W-1:0] n_cp_addr;
    logic [15:0]       r_fill_cell;
    logic [15:0]       n_fill_cell;
    t_result           r_res;
    t_result           n_res;
    logic              r_out_valid;
    logic              n_out_valid;
    t_result           r_out;
    t_result           n_out;

    logic              out_free;
    logic              pop;
    logic              last_col;
    logic              last_row;
    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [15:0]       ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [15:0]       ram_rdata;
    t_result           res;

    assign out_free = !r_out_valid || !i_out_stall;
    assign pop = (r_state == ST_IDLE) && i_op_valid && out_free;
    assign last_col = (r_col == LAST_COL);
    assign last_row = (r_row == LAST_ROW);
    assign cur_addr = ADDR_W'(r_row) * COLS_A + ADDR_W'(r_col);
    assign rd_addr = ADDR_W'(i_op.read_row) * COLS_A + ADDR_W'(i_op.read_column);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                if (r_idx == LAST_ADDR) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (pop) begin
                    unique case (i_op.kind)
                        OP_PUT:     if (last_col && last_row) n_state = ST_SCROLL;
                        OP_NEWLINE: if (last_row) n_state = ST_SCROLL;
                        OP_CLEAR:   n_state = ST_FILL;
                        OP_READ:    if (i_op.read_ok) n_state = ST_READ;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_READ: begin
                n_state = ST_IDLE;
            end
            ST_SCROLL: begin
                if (r_idx == COPY_END) n_state = ST_FILL;
            end
            ST_FILL: begin
                if (r_idx == LAST_ADDR) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        n_idx = r_idx;
        n_cp_valid = 1'b0;
        n_cp_addr = r_idx;
        n_fill_cell = r_fill_cell;
        n_res = r_res;
        n_out = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        ram_we = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = r_fill_cell;
        ram_raddr = r_idx + COLS_A;
        res.cell_value = 16'd0;
        res.cursor_row = 5'd0;
        res.cursor_column = 7'd0;
        res.scrolled = 1'b0;
        res.echo_valid = 1'b0;
        res.echo_byte = i_op.echo_byte;
        unique case (r_state)
            ST_INIT: begin
                ram_we = 1'b1;
                ram_wdata = 16'd0;
                n_idx = r_idx + 1'b1;
            end
            ST_IDLE: begin
                if (pop) begin
                    unique case (i_op.kind)
                        OP_PUT, OP_NEWLINE: begin
                            res.echo_valid = 1'b1;
                            if (i_op.kind == OP_PUT) begin
                                ram_we = 1'b1;
                                ram_waddr = cur_addr;
                                ram_wdata = {i_op.attr, i_op.ch};
                            end
                            if (last_col || i_op.kind == OP_NEWLINE) begin
                                n_col = '0;
                                if (last_row) begin
                                    res.scrolled = 1'b1;
                                    n_idx = '0;
                                    n_fill_cell = {i_op.attr, FILL_CHAR};
                                end else begin
                                    n_row = r_row + 1'b1;
                                end
                            end else begin
                                n_col = r_col + 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            n_row = '0;
                            n_col = '0;
                            n_idx = '0;
                            n_fill_cell = {i_op.attr, FILL_CHAR};
                        end
                        OP_BACKSPACE: begin
                            if (r_col != '0) begin
                                n_col = r_col - 1'b1;
                                ram_we = 1'b1;
                                ram_waddr = cur_addr - 1'b1;
                                ram_wdata = {i_op.attr, i_op.ch};
                            end
                        end
                        default: begin
                            ram_raddr = rd_addr;
                        end
                    endcase
                    res.cursor_row = 5'(n_row);
                    res.cursor_column = 7'(n_col);
                    if (n_state == ST_IDLE) begin
                        n_out = res;
                        n_out_valid = 1'b1;
                    end else begin
                        n_res = res;
                    end
                end
            end
            ST_READ: begin
                n_out = r_res;
                n_out.cell_value = ram_rdata;
                n_out_valid = 1'b1;
            end
            ST_SCROLL: begin
                if (r_cp_valid) begin
                    ram_we = 1'b1;
                    ram_waddr = r_cp_addr;
                    ram_wdata = ram_rdata;
                end
                if (r_idx != COPY_END) begin
                    ram_raddr = r_idx + COLS_A;
                    n_cp_valid = 1'b1;
                    n_cp_addr = r_idx;
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_FILL: begin
                ram_we = 1'b1;
                n_idx = r_idx + 1'b1;
                if (r_idx == LAST_ADDR) begin
                    n_out = r_res;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_row <= '0;
            r_col <= '0;
            r_idx <= '0;
            r_cp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row <= n_row;
            r_col <= n_col;
            r_idx <= n_idx;
            r_cp_valid <= n_cp_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp_addr <= n_cp_addr;
        r_fill_cell <= n_fill_cell;
        r_res <= n_res;
        r_out <= n_out;
    end

    tmcw_ram #(
        .WIDTH(16),
        .DEPTH(CELL_COUNT)
    ) u_screen (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign o_op_pop = pop;
    assign o_status.init_busy = (r_state == ST_INIT);
    assign o_out_valid = r_out_valid;
    assign o_out_item = r_out;
endmodule

// ===== design/text_mode_console_writer_top.sv =====
`timescale 1ns / 1ps
// Put, newline and backspace results pass the operation queue and the result register; a read also
// passes the read state. A clear fills the screen and a scroll copies each row up and fills the last
// row before the result, one cell at a time through the single write port of the screen memory.
// Throughput is one item every 1 cycle for plain puts while the result side does not stall.
// Reset is synchronous, active low; after it a clearing pass over all ROWS*COLUMNS cells (2000 by
// default) zeroes the screen while input stays stalled. Configuration writes are always taken.
module text_mode_console_writer_top #(
    parameter int COLUMNS = tmcw_pkg::DEFAULT_COLUMNS,
    parameter int ROWS = tmcw_pkg::DEFAULT_ROWS,
    parameter int QUEUE_DEPTH = tmcw_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  tmcw_pkg::t_item   i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output tmcw_pkg::t_result o_out_item,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [7:0]        i_cfg_data
);
    import tmcw_pkg::*;

    logic         push;
    t_op          push_op;
    logic         queue_full;
    logic         queue_not_empty;
    logic         pop;
    t_op          head_op;
    t_back_status status;

    tmcw_front #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_queue_full(queue_full),
        .i_status    (status),
        .o_push      (push),
        .o_push_op   (push_op)
    );

    tmcw_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_op  (push_op),
        .o_full     (queue_full),
        .i_pop      (pop),
        .o_not_empty(queue_not_empty),
        .o_op       (head_op)
    );

    tmcw_back #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (queue_not_empty),
        .i_op       (head_op),
        .o_op_pop   (pop),
        .o_status   (status),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    // A pop may only occur while the result register is free.
    a_pop_when_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> (!o_out_valid || !i_out_stall))
        else $error("operation started while a result was still held");

    a_no_transfer_during_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.init_busy |-> (!push && !pop && !o_out_valid))
        else $error("activity during the reset clearing pass");

    a_echo_has_no_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.echo_valid) |-> (o_out_item.cell_value == 16'd0))
        else $error("put result carries a cell value");

    a_scroll_from_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.scrolled) |->
            (o_out_item.echo_valid && o_out_item.cursor_column == 7'd0))
        else $error("scroll reported without a put at column zero");
endmodule

// ===== sim/console_checker.sv =====
`timescale 1ns / 1ps
// Checker for the text-mode console writer: keeps its own screen, cursor and attribute copy,
// predicts the result of every item transfer and compares each result transfer field by field.
// Depends on tmcw_pkg for the item and result types, the command codes and the fill constants.
module console_checker #(
    parameter int COLUMNS = tmcw_pkg::DEFAULT_COLUMNS,
    parameter int ROWS = tmcw_pkg::DEFAULT_ROWS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  tmcw_pkg::t_item   i_in_item,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  tmcw_pkg::t_result i_out_item,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [7:0]        i_cfg_data,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked,
    output int                o_scrolls
);
    import tmcw_pkg::*;

    logic [15:0] screen [ROWS*COLUMNS];
    int          cur_row;
    int          cur_col;
    logic [7:0]  attr_reg;
    t_result     predicted_outcomes [$];
    int          fail_count = 0;
    int          checked_count = 0;
    int          scroll_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending = predicted_outcomes.size();
    assign o_checked = checked_count;
    assign o_scrolls = scroll_count;

    function automatic bit move_to_next_row(logic [7:0] attr);
        cur_col = 0;
        cur_row++;
        if (cur_row < ROWS) return 1'b0;
        for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) screen[i] = screen[i + COLUMNS];
        for (int i = (ROWS - 1) * COLUMNS; i < ROWS * COLUMNS; i++) screen[i] = {attr, FILL_CHAR};
        cur_row = ROWS - 1;
        return 1'b1;
    endfunction

    function automatic t_result apply_console_cmd(t_item it);
        t_result    res;
        logic [7:0] attr;
        attr = it.use_own_attribute ? it.attribute : attr_reg;
        res = '0;
        case (it.cmd)
            CMD_PUT: begin
                res.echo_valid = 1'b1;
                res.echo_byte = it.char_code;
                if (it.char_code == NEWLINE_CODE) begin
                    res.scrolled = move_to_next_row(attr);
                end else begin
                    screen[cur_row * COLUMNS + cur_col] = {attr, it.char_code};
                    cur_col++;
                    if (cur_col >= COLUMNS) res.scrolled = move_to_next_row(attr);
                end
            end
            CMD_CLEAR: begin
                foreach (screen[i]) screen[i] = {attr, FILL_CHAR};
                cur_row = 0;
                cur_col = 0;
            end
            CMD_BACKSPACE: begin
                if (cur_col > 0) begin
                    cur_col--;
                    screen[cur_row * COLUMNS + cur_col] = {attr, SPACE_CODE};
                end
            end
            CMD_READ: begin
                if (it.read_row < ROWS && it.read_column < COLUMNS)
                    res.cell_value = screen[it.read_row * COLUMNS + it.read_column];
            end
            default: ;
        endcase
        res.cursor_row = 5'(cur_row);
        res.cursor_column = 7'(cur_col);
        return res;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            foreach (screen[i]) screen[i] = '0;
            cur_row = 0;
            cur_col = 0;
            attr_reg = DEFAULT_ATTR_RESET;
            predicted_outcomes.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) attr_reg = i_cfg_data;
            if (i_in_valid && !i_in_stall) begin
                want = apply_console_cmd(i_in_item);
                scroll_count += want.scrolled;
                predicted_outcomes.push_back(want);
            end
            if (i_out_valid && !i_out_stall) begin
                if (predicted_outcomes.size() == 0) begin
                    $error("Result transfer arrived with no item outstanding: %p", i_out_item);
                    fail_count++;
                end else begin
                    want = predicted_outcomes.pop_front();
                    check_field("cell_value", want.cell_value, i_out_item.cell_value);
                    check_field("cursor_row", want.cursor_row, i_out_item.cursor_row);
                    check_field("cursor_column", want.cursor_column, i_out_item.cursor_column);
                    check_field("scrolled", want.scrolled, i_out_item.scrolled);
                    check_field("echo_valid", want.echo_valid, i_out_item.echo_valid);
                    check_field("echo_byte", want.echo_byte, i_out_item.echo_byte);
                    checked_count++;
                end
            end
        end
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Top of the console writer regression: clock, reset, item and attribute stimulus, random
// stalls on the result side and the verdict. Depends on tmcw_pkg, the block's top level and
// console_checker, which does all prediction and comparison.
module testbench;
    import tmcw_pkg::*;

    localparam int COLUMNS = DEFAULT_COLUMNS;
    localparam int ROWS = DEFAULT_ROWS;
    localparam int PHASE_COUNT = 6;
    localparam int PHASE_ITEMS = 275;
    localparam int CYCLE_LIMIT = 16_000_000;

    typedef enum {
        S_TEXT,
        S_LONG_LINE,
        S_NEWLINES,
        S_READS,
        S_BACKSPACES,
        S_CLEAR,
        S_NOISE
    } t_session;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    t_item      in_item = '0;
    logic       out_stall = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [7:0] cfg_data = '0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_result    o_out_item;
    logic       o_cfg_ready;

    int fail_count;
    int pending;
    int checked;
    int scrolls;
    int items_sent = 0;
    int cycle_count = 0;
    int stall_left = 0;
    int free_left = 0;
    bit calm = 1'b0;

    text_mode_console_writer_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    console_checker screen_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (o_out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_scrolls    (scrolls)
    );

    always #1 clk = ~clk;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int pick_gap();
        int roll;
        if (calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(30, 100);
    endfunction

    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else if (free_left > 0) begin
            free_left--;
            out_stall <= 1'b0;
        end else begin
            if (calm || $urandom_range(0, 9) == 0) free_left = $urandom_range(50, 300);
            else free_left = $urandom_range(0, 6);
            stall_left = pick_gap();
            out_stall <= 1'b0;
        end
    end

    function automatic t_item build_item(logic [1:0] cmd, logic [7:0] ch, logic own,
                                         logic [7:0] attr, logic [4:0] row, logic [6:0] col);
        t_item it;
        it.cmd = cmd;
        it.char_code = ch;
        it.use_own_attribute = own;
        it.attribute = attr;
        it.read_row = row;
        it.read_column = col;
        return it;
    endfunction

    function automatic t_item make_item(t_session kind);
        t_item it;
        int    roll;
        it = build_item(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom), 8'($urandom),
                        5'($urandom), 7'($urandom));
        roll = $urandom_range(0, 99);
        case (kind)
            S_TEXT: begin
                if (roll < 85) begin
                    it.cmd = CMD_PUT;
                    if (roll < 9) it.char_code = NEWLINE_CODE;
                end else if (roll < 93) begin
                    it.cmd = CMD_BACKSPACE;
                end else begin
                    it.cmd = CMD_READ;
                    it.read_row = 5'($urandom_range(0, ROWS - 1));
                    it.read_column = 7'($urandom_range(0, COLUMNS - 1));
                end
            end
            S_LONG_LINE: begin
                it.cmd = CMD_PUT;
                if (it.char_code == NEWLINE_CODE) it.char_code = SPACE_CODE;
            end
            S_NEWLINES: begin
                it.cmd = CMD_PUT;
                it.char_code = NEWLINE_CODE;
            end
            S_READS: begin
                it.cmd = CMD_READ;
                it.read_row = 5'($urandom_range(0, ROWS - 1));
                it.read_column = 7'($urandom_range(0, COLUMNS - 1));
                if (roll >= 90) it.read_column = 7'($urandom_range(COLUMNS, 127));
                else if (roll >= 80) it.read_row = 5'($urandom_range(ROWS, 31));
            end
            S_BACKSPACES: it.cmd = CMD_BACKSPACE;
            S_CLEAR: it.cmd = CMD_CLEAR;
            default: ;
        endcase
        return it;
    endfunction

    task automatic send_item(t_item it);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (o_in_stall);
        items_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    task automatic write_attribute(logic [7:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!o_cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_session();
        t_session kind;
        int       roll;
        int       count;
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
            kind = S_TEXT;
            count = $urandom_range(5, 40);
        end else if (roll < 53) begin
            kind = S_LONG_LINE;
            count = $urandom_range(COLUMNS, COLUMNS + 50);
        end else if (roll < 65) begin
            kind = S_NEWLINES;
            count = $urandom_range(3, 20);
        end else if (roll < 78) begin
            kind = S_READS;
            count = $urandom_range(5, 30);
        end else if (roll < 88) begin
            kind = S_BACKSPACES;
            count = $urandom_range(3, 90);
        end else if (roll < 92) begin
            kind = S_CLEAR;
            count = 1;
        end else begin
            kind = S_NOISE;
            count = $urandom_range(3, 15);
        end
        repeat (count) send_item(make_item(kind));
    endtask

    initial begin
        logic [7:0] setting;
        int         phase_start;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: extremes of every field, each command, and reads at both screen corners.
        send_item(build_item(CMD_READ, 8'h00, 1'b0, 8'h00, 5'd0, 7'd0));
        send_item(build_item(CMD_PUT, 8'h41, 1'b0, 8'h00, 5'd0, 7'd0));
        send_item(build_item(CMD_PUT, 8'hFF, 1'b1, 8'hFF, 5'd0, 7'd0));
        send_item(build_item(CMD_PUT, 8'h00, 1'b1, 8'h00, 5'd0, 7'd0));
        send_item(build_item(CMD_BACKSPACE, 8'h00, 1'b1, 8'h5A, 5'd0, 7'd0));
        send_item(build_item(CMD_READ, 8'h00, 1'b0, 8'h00, 5'd0, 7'd2));
        send_item(build_item(CMD_READ, 8'hFF, 1'b1, 8'hFF, 5'd0, 7'd1));
        send_item(build_item(CMD_PUT, NEWLINE_CODE, 1'b1, 8'h3C, 5'd0, 7'd0));
        send_item(build_item(CMD_BACKSPACE, 8'h00, 1'b0, 8'h00, 5'd0, 7'd0));
        send_item(build_item(CMD_READ, 8'h00, 1'b0, 8'h00, 5'd31, 7'd0));
        send_item(build_item(CMD_READ, 8'h00, 1'b0, 8'h00, 5'd0, 7'd127));
        send_item(build_item(CMD_READ, 8'h00, 1'b0, 8'h00, 5'(ROWS - 1), 7'(COLUMNS - 1)));
        send_item(build_item(CMD_READ, 8'h00, 1'b0, 8'h00, 5'(ROWS), 7'(COLUMNS - 1)));
        send_item(build_item(CMD_READ, 8'h00, 1'b0, 8'h00, 5'(ROWS - 1), 7'(COLUMNS)));
        send_item(build_item(CMD_CLEAR, 8'hFF, 1'b1, 8'hC3, 5'd31, 7'd127));
        send_item(build_item(CMD_READ, 8'h00, 1'b0, 8'h00, 5'(ROWS - 1), 7'(COLUMNS - 1)));
        send_item(build_item(CMD_PUT, 8'h80, 1'b0, 8'hFF, 5'd31, 7'd127));
        send_item(build_item(CMD_BACKSPACE, 8'hFF, 1'b0, 8'hFF, 5'd31, 7'd127));
        send_item(build_item(CMD_READ, 8'h00, 1'b0, 8'h00, 5'd0, 7'd0));
        send_item(build_item(CMD_CLEAR, 8'h00, 1'b0, 8'h00, 5'd0, 7'd0));
        send_item(build_item(CMD_READ, 8'h00, 1'b0, 8'h00, 5'd12, 7'd40));
        drain();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: setting = 8'h00;
                1: setting = 8'hFF;
                default: setting = 8'($urandom);
            endcase
            write_attribute(setting);
            calm = (p == 2);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) run_session();
            drain();
        end
        calm = 1'b0;

        repeat (20) @(negedge clk);
        $display("Covered %0d item transfers, %0d results checked, %0d scrolls, %0d attributes.",
                 items_sent, checked, scrolls, PHASE_COUNT + 1);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
